// ===== hw/rtl/bdq_pkg.sv =====
// Shared types and constants of the bounded deque.
package bdq_pkg;

	localparam int unsigned DATA_W       = 32;
	localparam int unsigned REQ_W        = 3;
	localparam int unsigned CNT_OUT_W    = 5;
	localparam int unsigned CAPACITY_DEF = 16;

	localparam logic [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	localparam logic [REQ_W-1:0] REQ_PEEK       = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_REAR  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_REAR   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd4;
	localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd5;

	// Operation on one end-anchored row of cells.
	typedef struct packed {
		logic push_head;   // shift toward the far end, insert at cell 0
		logic pop_head;    // shift toward cell 0
		logic write_tail;  // write the cell just past the last held one
	} row_op_t;

	// Control of one cell.
	typedef struct packed {
		logic take_left;
		logic take_right;
		logic load;
	} cell_ctrl_t;

endpackage

// ===== hw/rtl/bdq_if.sv =====
// Request and response channel interfaces of the bounded deque.
interface bdq_req_if;
	import bdq_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [REQ_W-1:0]         req_type;
	logic signed [DATA_W-1:0] push_value;

	modport source (output valid, output req_type, output push_value, input ready);
	modport sink (input valid, input req_type, input push_value, output ready);
endinterface

interface bdq_rsp_if;
	import bdq_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] front_value;
	logic signed [DATA_W-1:0] rear_value;
	logic [CNT_OUT_W-1:0]     entry_count;
	logic                     is_empty;
	logic                     push_dropped;

	modport source (output valid, output front_value, output rear_value,
		output entry_count, output is_empty, output push_dropped, input ready);
	modport sink (input valid, input front_value, input rear_value,
		input entry_count, input is_empty, input push_dropped, output ready);
endinterface

// ===== hw/rtl/bdq_cell.sv =====
// One storage cell of a deque row.
module bdq_cell
	import bdq_pkg::*;
(
	input  logic              clk,
	input  cell_ctrl_t        ctrl,
	input  logic [DATA_W-1:0] left_data,
	input  logic [DATA_W-1:0] right_data,
	input  logic [DATA_W-1:0] load_data,
	output logic [DATA_W-1:0] data
);

	logic [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q <= load_data;
		end else if (ctrl.take_left) begin
			data_q <= left_data;
		end else if (ctrl.take_right) begin
			data_q <= right_data;
		end
	end

	assign data = data_q;

endmodule

// ===== hw/rtl/bdq_row.sv =====
// Row of cells anchored at one end of the deque: cell 0 holds that end.
module bdq_row
	import bdq_pkg::*;
#(
	parameter int unsigned DEPTH = CAPACITY_DEF,
	parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  row_op_t           op,
	input  logic [CNT_W-1:0]  count,
	input  logic [DATA_W-1:0] value,
	output logic [DATA_W-1:0] head
);

	logic [DATA_W-1:0] cell_data [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_ctrl_t        ctrl;
		logic [DATA_W-1:0] left_in;
		logic [DATA_W-1:0] right_in;

		assign ctrl.take_left  = op.push_head;
		assign ctrl.take_right = op.pop_head;
		assign ctrl.load       = op.write_tail && (count == CNT_W'(i));

		if (i == 0) begin : g_first
			assign left_in = value;
		end else begin : g_mid
			assign left_in = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_in = cell_data[i];
		end else begin : g_inner
			assign right_in = cell_data[i+1];
		end

		bdq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.left_data  (left_in),
			.right_data (right_in),
			.load_data  (value),
			.data       (cell_data[i])
		);
	end

	assign head = cell_data[0];

endmodule

// ===== hw/rtl/bounded_deque_unit.sv =====
// Top level of the bounded deque: request decode, count and response register.
//
// Bounded double-ended queue of signed 32-bit values holding up to CAPACITY
// entries. Each request transaction on req peeks, pushes at the rear or front,
// pops from the rear or front, or clears (codes 6 and 7 act as a peek); each
// yields exactly one response transaction on rsp with the front and rear
// values after the request (the most negative value when empty), the entry
// count (low 5 bits), an empty flag and a flag set when a push was refused
// because the store was full. A pop on an empty deque changes nothing. The
// store is two rows of CAPACITY cells: one row keeps the front entry in its
// first cell, the other keeps the rear entry in its first cell, each in
// opposite order. A push at an end shifts that end's row by one cell and
// writes the far row at the slot given by the count; a pop shifts one row
// back and drops the far row's tail by the count alone. So both ends are
// always read from a fixed cell. The response appears in the cycle after its
// request is accepted and sits in the response register until taken; a new
// request is accepted in the same cycle as the response is taken, giving one
// request per cycle when rsp is always ready. No clearing pass follows reset.
module bounded_deque_unit
	import bdq_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	bdq_req_if.sink       req,
	bdq_rsp_if.source     rsp
);

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_nxt;
	logic              out_valid_q;
	logic              dropped_q;
	logic              dropped_nxt;
	logic              accept;
	logic              full;
	logic              empty;
	row_op_t           front_op;
	row_op_t           rear_op;
	logic [DATA_W-1:0] front_head;
	logic [DATA_W-1:0] rear_head;
	logic [CNT_W+CNT_OUT_W-1:0] count_ext;

	assign full   = (count_q == CNT_W'(CAPACITY));
	assign empty  = (count_q == '0);
	// Take a new request whenever the response slot is free or being drained.
	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	// Decode the request into row operations and the next count.
	always_comb begin
		front_op    = '0;
		rear_op     = '0;
		count_nxt   = count_q;
		dropped_nxt = 1'b0;
		if (accept) begin
			case (req.req_type)
				REQ_PUSH_REAR: begin
					if (full) begin
						dropped_nxt = 1'b1;
					end else begin
						front_op.write_tail = 1'b1;
						rear_op.push_head   = 1'b1;
						count_nxt           = count_q + 1'b1;
					end
				end
				REQ_PUSH_FRONT: begin
					if (full) begin
						dropped_nxt = 1'b1;
					end else begin
						front_op.push_head = 1'b1;
						rear_op.write_tail = 1'b1;
						count_nxt          = count_q + 1'b1;
					end
				end
				REQ_POP_REAR: begin
					// Front row loses its tail through the count alone.
					if (!empty) begin
						rear_op.pop_head = 1'b1;
						count_nxt        = count_q - 1'b1;
					end
				end
				REQ_POP_FRONT: begin
					if (!empty) begin
						front_op.pop_head = 1'b1;
						count_nxt         = count_q - 1'b1;
					end
				end
				REQ_CLEAR: begin
					count_nxt = '0;
				end
				default: begin
					// Peek and unused codes: hold everything.
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
			dropped_q   <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				out_valid_q <= 1'b1;
				dropped_q   <= dropped_nxt;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	bdq_row #(
		.DEPTH (CAPACITY),
		.CNT_W (CNT_W)
	) u_front_row (
		.clk   (clk),
		.op    (front_op),
		.count (count_q),
		.value (req.push_value),
		.head  (front_head)
	);

	bdq_row #(
		.DEPTH (CAPACITY),
		.CNT_W (CNT_W)
	) u_rear_row (
		.clk   (clk),
		.op    (rear_op),
		.count (count_q),
		.value (req.push_value),
		.head  (rear_head)
	);

	// Cells and count are frozen while a response waits, so read them live.
	assign count_ext        = {{CNT_OUT_W{1'b0}}, count_q};
	assign rsp.valid        = out_valid_q;
	assign rsp.front_value  = empty ? INT_MIN : front_head;
	assign rsp.rear_value   = empty ? INT_MIN : rear_head;
	assign rsp.entry_count  = count_ext[CNT_OUT_W-1:0];
	assign rsp.is_empty     = empty;
	assign rsp.push_dropped = dropped_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_drop_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		accept && full && (req.req_type == REQ_PUSH_REAR || req.req_type == REQ_PUSH_FRONT)
		|=> rsp.push_dropped && $stable(count_q))
		else $error("push on full store not refused");

	a_pop_front_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !empty && req.req_type == REQ_POP_FRONT
		|=> count_q == $past(count_q) - 1'b1)
		else $error("pop front did not decrement count");

	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rsp.ready |=> $stable(count_q) && rsp.valid)
		else $error("state moved while response stalled");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the bounded deque with a scoreboard that predicts every response.
`timescale 1ns / 1ps

module tb_top;
	import bdq_pkg::*;

	localparam int unsigned DEPTH          = CAPACITY_DEF;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned RANDOM_ITEMS   = 1500;
	localparam int unsigned HOLD_OFF_AT    = 400;   // responses seen before the long stall
	localparam int unsigned HOLD_OFF_LEN   = 250;   // cycles of the long stall
	localparam int unsigned DRAIN_AT       = 750;   // random requests sent before the full drain

	// Request codes with no operation of their own; the deque treats them as a peek.
	localparam logic [REQ_W-1:0] REQ_UNUSED_A = 3'd6;
	localparam logic [REQ_W-1:0] REQ_UNUSED_B = 3'd7;

	localparam logic signed [DATA_W-1:0] INT_MAX = ~INT_MIN;

	// Response fields as the deque should present them.
	typedef struct {
		logic signed [DATA_W-1:0] front_value;
		logic signed [DATA_W-1:0] rear_value;
		logic [CNT_OUT_W-1:0]     entry_count;
		logic                     is_empty;
		logic                     push_dropped;
	} deque_view_t;

	// Shadow deque: apply each accepted request, queue the view it should
	// produce, and match the responses against that queue in order.
	class deque_scoreboard;
		logic signed [DATA_W-1:0] cells [DEPTH];
		int unsigned              head;
		int unsigned              tail;
		int unsigned              held;
		deque_view_t              expected_views [$];
		int unsigned              mismatches;
		int unsigned              checked;

		function new();
			head       = 0;
			tail       = 0;
			held       = 0;
			mismatches = 0;
			checked    = 0;
		endfunction

		function int unsigned pending();
			return expected_views.size();
		endfunction

		function void note_request(logic [REQ_W-1:0] code, logic signed [DATA_W-1:0] value);
			deque_view_t view;
			view.push_dropped = 1'b0;
			case (code)
				REQ_PUSH_REAR: begin
					if (held >= DEPTH) begin
						view.push_dropped = 1'b1;
					end else begin
						cells[tail] = value;
						tail = (tail + 1) % DEPTH;
						held++;
					end
				end
				REQ_PUSH_FRONT: begin
					if (held >= DEPTH) begin
						view.push_dropped = 1'b1;
					end else begin
						head = (head + DEPTH - 1) % DEPTH;
						cells[head] = value;
						held++;
					end
				end
				REQ_POP_REAR: begin
					if (held > 0) begin
						tail = (tail + DEPTH - 1) % DEPTH;
						held--;
					end
				end
				REQ_POP_FRONT: begin
					if (held > 0) begin
						head = (head + 1) % DEPTH;
						held--;
					end
				end
				REQ_CLEAR: begin
					head = 0;
					tail = 0;
					held = 0;
				end
				default: begin
				end
			endcase
			view.front_value = (held > 0) ? cells[head] : INT_MIN;
			view.rear_value  = (held > 0) ? cells[(tail + DEPTH - 1) % DEPTH] : INT_MIN;
			view.entry_count = held[CNT_OUT_W-1:0];
			view.is_empty    = (held == 0);
			expected_views.push_back(view);
		endfunction

		function void check_response(deque_view_t seen);
			deque_view_t want;
			checked++;
			if (expected_views.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("response %0d arrived with no request outstanding", checked);
				return;
			end
			want = expected_views.pop_front();
			if (seen.front_value !== want.front_value || seen.rear_value !== want.rear_value ||
					seen.entry_count !== want.entry_count || seen.is_empty !== want.is_empty ||
					seen.push_dropped !== want.push_dropped) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("response %0d: expected front %0d rear %0d count %0d empty %0b dropped %0b",
						checked, want.front_value, want.rear_value, want.entry_count,
						want.is_empty, want.push_dropped);
					$display("response %0d: got      front %0d rear %0d count %0d empty %0b dropped %0b",
						checked, seen.front_value, seen.rear_value, seen.entry_count,
						seen.is_empty, seen.push_dropped);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   no_idle;  // set for phases in which neither side inserts gaps

	bdq_req_if req_ch ();
	bdq_rsp_if rsp_ch ();

	deque_scoreboard sb = new();

	bounded_deque_unit #(
		.CAPACITY(CAPACITY_DEF)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch.sink),
		.rsp   (rsp_ch.source)
	);

	always #5 clk = ~clk;

	// Offer one request after a gap, hold it until the deque takes it, and
	// note it in the scoreboard at the accepting edge. Return at the falling
	// edge after acceptance with valid still high, so a back-to-back request
	// keeps valid up without a glitch.
	task automatic send_request(logic [REQ_W-1:0] code, logic signed [DATA_W-1:0] value,
			int unsigned gap);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= code;
		req_ch.push_value <= value;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(code, value);
		@(negedge clk);
	endtask

	// Draw a push value: mostly random bits, sometimes one of the extremes.
	function automatic logic signed [DATA_W-1:0] draw_value();
		case ($urandom_range(0, 15))
			0:       return INT_MIN;
			1:       return INT_MAX;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// Gap before the next transaction on either side.
	function automatic int unsigned draw_gap();
		return no_idle ? 0 : $urandom_range(0, 8);
	endfunction

	// Response side: stall at random, once hold off for a long stretch so the
	// response register fills and the request side backs up, and check every
	// response transaction at the edge that takes it.
	initial begin
		int unsigned stall;
		bit          held_off;
		deque_view_t seen;
		held_off     = 1'b0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!held_off && sb.checked >= HOLD_OFF_AT) begin
				held_off = 1'b1;
				stall    = HOLD_OFF_LEN;
			end else begin
				stall = draw_gap();
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			seen.front_value  = rsp_ch.front_value;
			seen.rear_value   = rsp_ch.rear_value;
			seen.entry_count  = rsp_ch.entry_count;
			seen.is_empty     = rsp_ch.is_empty;
			seen.push_dropped = rsp_ch.push_dropped;
			sb.check_response(seen);
			@(negedge clk);
		end
	end

	// Watchdog: end the run when neither channel moves a transaction for too long.
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// Request side: reset, directed corner cases, then random phases.
	initial begin
		int unsigned      sent;
		int unsigned      phase_len;
		int unsigned      kind;
		int unsigned      roll;
		int unsigned      push_pct;
		int unsigned      pop_pct;
		bit               drained;
		logic [REQ_W-1:0] code;

		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.req_type   = REQ_PEEK;
		req_ch.push_value = '0;
		no_idle           = 1'b0;
		drained           = 1'b0;
		sent              = 0;

		// Hold reset, then release it away from the rising edge.
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: empty-deque requests, extreme values at both ends,
		// popping back to empty, the unused codes and clear.
		send_request(REQ_PEEK, '0, draw_gap());
		send_request(REQ_POP_REAR, '1, draw_gap());
		send_request(REQ_POP_FRONT, INT_MAX, draw_gap());
		send_request(REQ_PUSH_REAR, INT_MIN, draw_gap());
		send_request(REQ_PUSH_FRONT, INT_MAX, draw_gap());
		send_request(REQ_PEEK, $urandom, draw_gap());
		send_request(REQ_PUSH_REAR, '1, draw_gap());
		send_request(REQ_PUSH_FRONT, '0, draw_gap());
		send_request(REQ_POP_REAR, '0, draw_gap());
		send_request(REQ_POP_FRONT, '0, draw_gap());
		send_request(REQ_POP_FRONT, '0, draw_gap());
		send_request(REQ_POP_REAR, '0, draw_gap());
		send_request(REQ_POP_REAR, '0, draw_gap());
		send_request(REQ_UNUSED_A, $urandom, draw_gap());
		send_request(REQ_PUSH_REAR, 32'sh5A5A_A5A5, draw_gap());
		send_request(REQ_UNUSED_B, $urandom, draw_gap());
		send_request(REQ_CLEAR, '1, draw_gap());
		send_request(REQ_PEEK, '0, draw_gap());
		send_request(REQ_PUSH_FRONT, 32'sh0000_0001, draw_gap());
		send_request(REQ_CLEAR, '0, draw_gap());
		send_request(REQ_POP_FRONT, '0, draw_gap());

		// Random part: phases that lean toward filling (so pushes reach the
		// full store and get dropped), toward draining (so pops hit empty),
		// balanced traffic, and raw noise over every code.
		while (sent < RANDOM_ITEMS) begin
			kind      = $urandom_range(0, 9);
			phase_len = $urandom_range(20, 80);
			no_idle   = ($urandom_range(0, 3) == 0);
			if (kind <= 3) begin
				push_pct = 70;
				pop_pct  = 20;
			end else if (kind <= 6) begin
				push_pct = 20;
				pop_pct  = 70;
			end else begin
				push_pct = 45;
				pop_pct  = 45;
			end
			repeat (phase_len) begin
				roll = $urandom_range(0, 99);
				if (kind == 9)
					code = REQ_W'($urandom_range(0, 7));
				else if (roll < push_pct)
					code = $urandom_range(0, 1) ? REQ_PUSH_REAR : REQ_PUSH_FRONT;
				else if (roll < push_pct + pop_pct)
					code = $urandom_range(0, 1) ? REQ_POP_REAR : REQ_POP_FRONT;
				else if (roll < 98)
					code = REQ_PEEK;
				else
					code = REQ_CLEAR;
				send_request(code, draw_value(), draw_gap());
				sent++;
				// Once, pause the requests until every response has come back.
				if (!drained && sent >= DRAIN_AT) begin
					drained = 1'b1;
					req_ch.valid <= 1'b0;
					while (sb.pending() != 0) @(negedge clk);
					@(negedge clk);
				end
			end
		end

		// Drop valid, let the last responses drain, then wait on for any stray
		// response to show up.
		req_ch.valid <= 1'b0;
		no_idle = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
